// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/kpu_pkg.sv =====
// Package for the permutation unranking block: widths, types and factorial table.
package kpu_pkg;

    localparam int SIZE_W  = 4;
    localparam int RANK_W  = 29;
    localparam int DIGIT_W = 4;
    localparam int QUOT_W  = 4;
    localparam int STEP_W  = 2;
    localparam int SHIFT_W = RANK_W + QUOT_W - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } kpu_state_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [RANK_W-1:0] rem;
    } kpu_div_res_t;

    function automatic logic [RANK_W-1:0] kpu_fact(input logic [SIZE_W-1:0] idx);
        logic [RANK_W-1:0] f;
        begin
            unique case (idx)
                4'd0:    f = 29'd1;
                4'd1:    f = 29'd1;
                4'd2:    f = 29'd2;
                4'd3:    f = 29'd6;
                4'd4:    f = 29'd24;
                4'd5:    f = 29'd120;
                4'd6:    f = 29'd720;
                4'd7:    f = 29'd5040;
                4'd8:    f = 29'd40320;
                4'd9:    f = 29'd362880;
                4'd10:   f = 29'd3628800;
                4'd11:   f = 29'd39916800;
                4'd12:   f = 29'd479001600;
                default: f = '0;
            endcase
            return f;
        end
    endfunction

endpackage

// ===== hdl/kth_permutation_unrank.sv =====
// Top level: k-th lexicographic permutation of 1..n, one element per result item.
// Takes size_n and a one-based rank_k and returns the permutation digits most
// significant first, last set on the final one. A size of 0 or above MAX_N, or
// a rank of 0 or above size_n!, gives a single item with digit 0, last 1 and
// error 1. One item is worked on at a time; req_stall is high from acceptance
// until the final result item has been taken. Each digit comes from the
// shared restoring divider (one compare-subtract per quotient bit against the
// remaining factorial) and is then held in the output register until taken.
module kth_permutation_unrank #(
    parameter int MAX_N = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [kpu_pkg::SIZE_W-1:0]   size_n,
    input  logic [kpu_pkg::RANK_W-1:0]   rank_k,
    // response channel
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [kpu_pkg::DIGIT_W-1:0]  digit,
    output logic                         last,
    output logic                         error
);
    import kpu_pkg::*;

    localparam int CNT_W = $clog2(MAX_N + 1);
    localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    kpu_state_t          state_reg, state_next;

    // pool of unused values, kept in ascending order
    logic [DIGIT_W-1:0]  pool_reg [MAX_N];
    logic [CNT_W-1:0]    count_reg;
    logic [RANK_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]  digit_reg;
    logic                last_reg;
    logic                err_reg;

    logic                bad;
    logic                div_start;
    logic [RANK_W-1:0]   div_dividend;
    logic [SIZE_W-1:0]   fact_idx;
    kpu_div_res_t        div_res;
    logic [QUOT_W-1:0]   quot_clamp;
    logic [IDX_W-1:0]    sel_idx;
    logic                req_take;
    logic                rsp_take;

    // input range check against n!
    assign bad = (size_n == '0) || (size_n > SIZE_W'(MAX_N)) ||
                 (rank_k == '0) || (rank_k > kpu_fact(size_n));

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    // first digit divides k-1 by (n-1)!; later ones use the kept remainder
    assign div_dividend = (state_reg == ST_IDLE) ? (rank_k - 1'b1) : rem_reg;
    assign fact_idx     = (state_reg == ST_IDLE) ? (size_n - 1'b1)
                                                 : SIZE_W'(count_reg - 1'b1);

    kpu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (kpu_fact(fact_idx)),
        .res      (div_res)
    );

    // quotient is always below count for an in-range rank; clamp for safety
    assign quot_clamp = (div_res.quot >= QUOT_W'(count_reg)) ?
                        QUOT_W'(count_reg - 1'b1) : div_res.quot;
    assign sel_idx    = IDX_W'(quot_clamp);

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = bad ? ST_EMIT : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!rsp_stall)
                    state_next = last_reg ? ST_IDLE : ST_DIV;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        req_stall = 1'b1;
        rsp_valid = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                div_start = req_valid && !bad;
            end
            ST_DIV:
            begin
            end
            ST_EMIT:
            begin
                rsp_valid = 1'b1;
                div_start = !rsp_stall && !last_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath: pool, count, remainder and the output register
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            if (bad)
            begin
                digit_reg <= '0;
                last_reg  <= 1'b1;
                err_reg   <= 1'b1;
            end
            else
            begin
                for (int i = 0; i < MAX_N; i++)
                    pool_reg[i] <= DIGIT_W'(i + 1);
                count_reg <= CNT_W'(size_n);
            end
        end
        else if ((state_reg == ST_DIV) && div_res.done)
        begin
            digit_reg <= pool_reg[sel_idx];
            last_reg  <= (count_reg == CNT_W'(1));
            err_reg   <= 1'b0;
            count_reg <= count_reg - 1'b1;
            rem_reg   <= div_res.rem;
            // close the gap left by the taken entry
            for (int j = 0; j < MAX_N - 1; j++)
                if (IDX_W'(j) >= sel_idx)
                    pool_reg[j] <= pool_reg[j + 1];
        end
    end

    assign digit = digit_reg;
    assign last  = last_reg;
    assign error = err_reg;

`include "assert_macros.svh"

    // an error item is a lone item: last set, digit zero
    `ASSERT_IMPLY(a_err_single, clk, rst_n, rsp_valid && error, last && (digit == '0))
    // divider finishes only while the sequencer waits on it
    `ASSERT_IMPLY(a_done_in_div, clk, rst_n, div_res.done, state_reg == ST_DIV)
    // a digit is never computed from an empty pool
    `ASSERT_IMPLY(a_pool_nonempty, clk, rst_n, state_reg == ST_DIV, count_reg != '0)
    // taking the final item frees the block
    `ASSERT_NEXT(a_last_frees, clk, rst_n, rsp_take && last, state_reg == ST_IDLE)
    // an accepted item always starts work or gives its error item
    `ASSERT_NEXT(a_take_busy, clk, rst_n, req_take, state_reg != ST_IDLE)

endmodule

// ===== hdl/kpu_div.sv =====
// Restoring divider for a small quotient: one compare-subtract per cycle.
module kpu_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [kpu_pkg::RANK_W-1:0]  dividend,
    input  logic [kpu_pkg::RANK_W-1:0]  divisor,
    output kpu_pkg::kpu_div_res_t       res
);
    import kpu_pkg::*;

    logic                busy_reg,  busy_next;
    logic [STEP_W-1:0]   step_reg,  step_next;
    logic [RANK_W-1:0]   rem_reg,   rem_next;
    logic [RANK_W-1:0]   div_reg,   div_next;
    logic [QUOT_W-1:0]   quot_reg,  quot_next;

    logic [SHIFT_W-1:0]  shifted;
    logic [SHIFT_W-1:0]  rem_ext;
    logic [SHIFT_W-1:0]  diff;
    logic                ge;

    // trial subtract of divisor << step
    assign shifted = SHIFT_W'(div_reg) << step_reg;
    assign rem_ext = SHIFT_W'(rem_reg);
    assign diff    = rem_ext - shifted;
    assign ge      = (rem_ext >= shifted);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = ge ? RANK_W'(diff) : rem_reg;
        div_next  = div_reg;
        quot_next = {quot_reg[QUOT_W-2:0], ge};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(QUOT_W - 1);
            rem_next  = dividend;
            div_next  = divisor;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    // final step: results are the values the last step produces
    assign res.done = busy_reg && (step_reg == '0);
    assign res.quot = {quot_reg[QUOT_W-2:0], ge};
    assign res.rem  = ge ? RANK_W'(diff) : rem_reg;

endmodule
